// ===== rtl/core/sorted_key_table_with_level_macros.svh =====
// Assertion macros for the sorted key table.
// Uses the names clk and rst of the module that includes this header.
`ifndef SORTED_KEY_TABLE_WITH_LEVEL_MACROS_SVH
`define SORTED_KEY_TABLE_WITH_LEVEL_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define SKTL_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// When the antecedent holds, the consequent holds in the cycle after.
`define SKTL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/sktl_pkg.sv =====
// Shared widths, codes, the entry type and level arithmetic of the sorted key table.
// No dependencies; used by the interfaces, the entry store and the top level.
package sktl_pkg;

  localparam int DEPTH_DEFAULT = 64;

  localparam int OP_W       = 3;
  localparam int KEY_W      = 64;
  localparam int KIND_W     = 8;
  localparam int TAG_W      = 32;
  localparam int LEVEL_W    = 32;
  localparam int STATUS_W   = 3;
  localparam int CODE_W     = 2;
  localparam int SLOT_W     = 6;
  localparam int COUNT_W    = 7;
  localparam int LIMIT_W    = 7;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET      = 7'd64;
  localparam logic [LEVEL_W-1:0] FULL_LEVEL_RESET = 32'd100;

  localparam logic [OP_W-1:0] OP_INSERT     = 3'd0;
  localparam logic [OP_W-1:0] OP_LOOKUP     = 3'd1;
  localparam logic [OP_W-1:0] OP_SET_LEVEL  = 3'd2;
  localparam logic [OP_W-1:0] OP_ADD_LEVEL  = 3'd3;
  localparam logic [OP_W-1:0] OP_SET_STATUS = 3'd4;

  localparam logic [CODE_W-1:0] CODE_OK        = 2'd0;
  localparam logic [CODE_W-1:0] CODE_FULL      = 2'd1;
  localparam logic [CODE_W-1:0] CODE_DUPLICATE = 2'd2;
  localparam logic [CODE_W-1:0] CODE_NOT_FOUND = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_TABLE_LIMIT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_LEVEL  = 4'd1;

  localparam logic [STATUS_W-1:0] STATUS_UNKNOWN = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_KNOWN   = 3'd1;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [KIND_W-1:0]   kind;
    logic [TAG_W-1:0]    tags;
    logic [LEVEL_W-1:0]  level;
    logic [STATUS_W-1:0] status;
  } entry_t;

  // Unsigned add that sticks at all ones instead of wrapping.
  function automatic logic [LEVEL_W-1:0] add_sat(input logic [LEVEL_W-1:0] a,
                                                 input logic [LEVEL_W-1:0] b);
    logic [LEVEL_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[LEVEL_W] ? '1 : sum[LEVEL_W-1:0];
  endfunction

  function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] v,
                                                     input logic [LEVEL_W-1:0] top);
    return (v > top) ? top : v;
  endfunction

endpackage

// ===== rtl/core/sktl_ifs.sv =====
// Valid/ready channel interfaces of the sorted key table: command, response, configuration.
// Depends on sktl_pkg for the field widths.
interface sktl_cmd_if import sktl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     op;
  logic [KEY_W-1:0]    key;
  logic [KIND_W-1:0]   entry_kind;
  logic [TAG_W-1:0]    tags;
  logic [LEVEL_W-1:0]  amount;
  logic [STATUS_W-1:0] new_status;

  modport source (output valid, op, key, entry_kind, tags, amount, new_status,
                  input ready);
  modport sink (input valid, op, key, entry_kind, tags, amount, new_status,
                output ready);
endinterface

interface sktl_rsp_if import sktl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CODE_W-1:0]   code;
  logic [SLOT_W-1:0]   slot;
  logic [KIND_W-1:0]   kind_out;
  logic [TAG_W-1:0]    tags_out;
  logic [LEVEL_W-1:0]  level_out;
  logic [STATUS_W-1:0] status_out;
  logic [COUNT_W-1:0]  entries;

  modport source (output valid, code, slot, kind_out, tags_out, level_out, status_out,
                  entries, input ready);
  modport sink (input valid, code, slot, kind_out, tags_out, level_out, status_out,
                entries, output ready);
endinterface

interface sktl_cfg_if import sktl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/sktl_store.sv =====
// Entry store of the sorted key table: one write port, one read port, registered read data.
// Depends on sktl_pkg for entry_t.
module sktl_store import sktl_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT,
  parameter int IW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [IW-1:0] waddr,
  input  entry_t        wdata,
  input  logic          re,
  input  logic [IW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/sorted_key_table_with_level.sv =====
// Top level of the sorted key table: sequencer around a single entry store.
// Depends on sktl_pkg, the sktl_*_if interfaces, sktl_store and the assertion macros.
//
// Usage. Commands arrive on the cmd channel and each produces exactly one response
// transfer on rsp. The cfg channel writes table_limit (index 0) and full_level
// (index 1); it is always ready and is meant to be written only while no command
// is in flight. Entries are kept in ascending key order in one memory with
// registered read data, and every search walks it from slot 0.
// A search reads one entry per cycle and stops at the first key equal to or above
// the key given, or at the last entry. A command other than insert that finds its
// entry then passes through a modify step. An insert that lands below existing
// entries moves each of them up one slot, one per cycle, and then writes the new
// entry. A refused insert and a command on an empty table skip the search, and an
// insert into an empty table writes its entry directly. Only one command is worked
// on at a time; cmd is ready again in the cycle in which the response is first
// presented.
// Reset clears the entry count and loads table_limit = 64 and full_level = 100; the
// memory contents are left as they are, as only slots below the count are read.
// A stalled receiver holds the response in the output register; the block still
// takes the next command and finishes it, then waits until the register is free.
`include "sorted_key_table_with_level_macros.svh"

module sorted_key_table_with_level import sktl_pkg::*; #(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  sktl_cmd_if.sink  cmd,
  sktl_rsp_if.source rsp,
  sktl_cfg_if.sink  cfg
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEARCH = 3'd1;
  localparam logic [2:0] ST_SHIFT  = 3'd2;
  localparam logic [2:0] ST_NEW    = 3'd3;
  localparam logic [2:0] ST_MODIFY = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  // Control state.
  logic [2:0]         state;
  logic [CW-1:0]      count;
  logic [LIMIT_W-1:0] table_limit;
  logic [LEVEL_W-1:0] full_level;

  // The command being worked on and its progress.
  logic [OP_W-1:0]     op_r;
  logic [KEY_W-1:0]    key_r;
  logic [KIND_W-1:0]   kind_r;
  logic [TAG_W-1:0]    tags_r;
  logic [LEVEL_W-1:0]  amount_r;
  logic [STATUS_W-1:0] nstat_r;
  logic [IW-1:0]       scan;
  logic [IW-1:0]       idx;
  logic [IW-1:0]       ptr;
  entry_t              ent;
  logic [CODE_W-1:0]   code_r;
  logic                show;

  // Store ports.
  logic          st_we;
  logic [IW-1:0] st_waddr;
  entry_t        st_wdata;
  logic          st_re;
  logic [IW-1:0] st_raddr;
  entry_t        st_rdata;

  logic               accept;
  logic               tbl_full;
  logic               k_eq;
  logic               k_gt;
  logic               scan_last;
  logic               op_writes;
  logic [LEVEL_W-1:0] lvl_in;
  logic [LEVEL_W-1:0] lvl_new;
  entry_t             upd;
  entry_t             fresh;

  sktl_store #(.DEPTH(DEPTH), .IW(IW)) u_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  assign cmd.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign accept    = cmd.valid && cmd.ready;

  // The effective limit never reaches beyond the physical depth.
  assign tbl_full = (32'(count) >= 32'(table_limit)) || (count == CW'(DEPTH));

  // The read data always belongs to slot scan while searching.
  assign k_eq      = (st_rdata.key == key_r);
  assign k_gt      = (st_rdata.key > key_r);
  assign scan_last = ((CW'(scan) + 1'b1) == count);

  assign fresh = '{key: key_r, kind: kind_r, tags: tags_r, level: '0,
                   status: STATUS_UNKNOWN};

  // Read-modify-write of the entry found by the search.
  always_comb begin
    op_writes = op_r inside {OP_SET_LEVEL, OP_ADD_LEVEL, OP_SET_STATUS};
    lvl_in    = (op_r == OP_ADD_LEVEL) ? add_sat(ent.level, amount_r) : amount_r;
    lvl_new   = clamp_level(lvl_in, full_level);
    upd       = ent;
    case (op_r)
      OP_SET_LEVEL, OP_ADD_LEVEL: begin
        upd.level = lvl_new;
        if (lvl_new >= full_level) begin
          upd.status = STATUS_KNOWN;
        end
      end
      OP_SET_STATUS: begin
        upd.status = nstat_r;
      end
      default: begin
        upd = ent;
      end
    endcase
  end

  // Memory port control. Writes only happen in the shift, new and modify steps,
  // and a shift reads two slots below the one it writes, so a read never meets a
  // write to the same slot and no forwarding is needed.
  always_comb begin
    st_re    = 1'b0;
    st_raddr = '0;
    st_we    = 1'b0;
    st_waddr = idx;
    st_wdata = st_rdata;
    case (state)
      ST_IDLE: begin
        if (accept && !(cmd.op == OP_INSERT && tbl_full) && count != '0) begin
          st_re = 1'b1;
        end
      end
      ST_SEARCH: begin
        if (!k_eq) begin
          if (k_gt && op_r == OP_INSERT) begin
            st_re    = 1'b1;
            st_raddr = IW'(count - 1'b1);
          end else if (!k_gt && !scan_last) begin
            st_re    = 1'b1;
            st_raddr = scan + 1'b1;
          end
        end
      end
      ST_SHIFT: begin
        st_we    = 1'b1;
        st_waddr = ptr;
        st_wdata = st_rdata;
        if ((ptr - 1'b1) != idx) begin
          st_re    = 1'b1;
          st_raddr = IW'(ptr - 2'd2);
        end
      end
      ST_NEW: begin
        st_we    = 1'b1;
        st_wdata = fresh;
      end
      ST_MODIFY: begin
        st_we    = op_writes;
        st_wdata = upd;
      end
      default: begin
        st_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      count       <= '0;
      table_limit <= LIMIT_RESET;
      full_level  <= FULL_LEVEL_RESET;
      rsp.valid   <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_TABLE_LIMIT) begin
          table_limit <= cfg.data[LIMIT_W-1:0];
        end else if (cfg.index == REG_FULL_LEVEL) begin
          full_level <= cfg.data[LEVEL_W-1:0];
        end
      end

      // In the done step the output register is loaded below instead.
      if (rsp.ready && state != ST_DONE) begin
        rsp.valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept) begin
            op_r     <= cmd.op;
            key_r    <= cmd.key;
            kind_r   <= cmd.entry_kind;
            tags_r   <= cmd.tags;
            amount_r <= cmd.amount;
            nstat_r  <= cmd.new_status;
            scan     <= '0;
            idx      <= '0;
            show     <= 1'b0;
            if (cmd.op == OP_INSERT && tbl_full) begin
              // A full table refuses the insert before any search.
              code_r <= CODE_FULL;
              state  <= ST_DONE;
            end else if (count == '0) begin
              if (cmd.op == OP_INSERT) begin
                code_r <= CODE_OK;
                state  <= ST_NEW;
              end else begin
                code_r <= CODE_NOT_FOUND;
                state  <= ST_DONE;
              end
            end else begin
              code_r <= CODE_OK;
              state  <= ST_SEARCH;
            end
          end
        end
        ST_SEARCH: begin
          if (k_eq) begin
            idx <= scan;
            ent <= st_rdata;
            if (op_r == OP_INSERT) begin
              code_r <= CODE_DUPLICATE;
              show   <= 1'b1;
              state  <= ST_DONE;
            end else begin
              state <= ST_MODIFY;
            end
          end else if (k_gt || scan_last) begin
            idx <= k_gt ? scan : IW'(count);
            if (op_r == OP_INSERT) begin
              if (k_gt) begin
                ptr   <= IW'(count);
                state <= ST_SHIFT;
              end else begin
                state <= ST_NEW;
              end
            end else begin
              code_r <= CODE_NOT_FOUND;
              state  <= ST_DONE;
            end
          end else begin
            scan <= scan + 1'b1;
          end
        end
        ST_SHIFT: begin
          if ((ptr - 1'b1) == idx) begin
            state <= ST_NEW;
          end else begin
            ptr <= ptr - 1'b1;
          end
        end
        ST_NEW: begin
          ent   <= fresh;
          count <= count + 1'b1;
          show  <= 1'b1;
          state <= ST_DONE;
        end
        ST_MODIFY: begin
          ent   <= upd;
          show  <= 1'b1;
          state <= ST_DONE;
        end
        ST_DONE: begin
          // Wait here while the previous response is still held by the receiver.
          if (!rsp.valid || rsp.ready) begin
            rsp.valid      <= 1'b1;
            rsp.code       <= code_r;
            rsp.slot       <= show ? SLOT_W'(idx) : '0;
            rsp.kind_out   <= show ? ent.kind : '0;
            rsp.tags_out   <= show ? ent.tags : '0;
            rsp.level_out  <= show ? ent.level : '0;
            rsp.status_out <= show ? ent.status : '0;
            rsp.entries    <= COUNT_W'(count);
            state          <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `SKTL_ASSERT_ALWAYS(a_count_bound, count <= CW'(DEPTH), "entry count above depth")
  `SKTL_ASSERT_ALWAYS(a_search_no_write, state != ST_SEARCH || !st_we, "store written in search")
  `SKTL_ASSERT_NEXT(a_insert_count, state == ST_NEW, count == $past(count) + 1'b1, "insert count slip")
  `SKTL_ASSERT_ALWAYS(a_full_clean, !(rsp.valid && rsp.code == CODE_FULL) || (rsp.slot == '0 && rsp.level_out == '0), "full response not cleared")

endmodule
